// ===== design/vrp_pkg.sv =====
// Shared types, constants and tables for the vertex rotate and project pipeline.
package vrp_pkg;

    localparam int COORD_W    = 18;             // rotated coordinate, Q.8 with headroom
    localparam int TRIG_W     = 16;             // Q1.14 sine and cosine
    localparam int PROD_W     = COORD_W + TRIG_W;
    localparam int CORDIC_W   = 34;             // Q2.30 with guard bits
    localparam int ZACC_W     = 25;             // angle accumulator, 2^-24 turn units
    localparam int NUM_STEPS  = 16;
    localparam int STEP_W     = 4;
    localparam int NUM_AXES   = 3;
    localparam int DEN_W      = 18;             // positive eye distance plus z
    localparam int DIV_W      = DEN_W + 1;      // divisor is twice the distance
    localparam int QUOT_W     = 17;
    localparam int NUM_W      = 32;             // rounding numerator
    localparam int MAG_W      = 31;             // magnitude times scale
    localparam int PROJ_LAT   = QUOT_W + 3;
    localparam int ROT_LAT    = 6;
    localparam int TOTAL_LAT  = ROT_LAT + PROJ_LAT;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0]   TRIG_ONE    = 16'sd16384;
    localparam logic signed [DIV_W-1:0]    EYE_DIST    = 19'sd768;
    localparam logic [MAG_W-1:0]           PROJ_SCALE  = 31'd4800;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] depth_z;
        logic               behind_eye;
    } t_result;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cs;
        logic signed [TRIG_W-1:0] sn;
    } t_trig;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RUN,
        SC_FINISH
    } t_sc_state;

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic signed [ZACC_W-1:0] step_angle(input logic [STEP_W-1:0] idx);
        logic signed [ZACC_W-1:0] a;
        case (idx)
            4'd0:    a = 25'sd2097152;
            4'd1:    a = 25'sd1238021;
            4'd2:    a = 25'sd654136;
            4'd3:    a = 25'sd332050;
            4'd4:    a = 25'sd166669;
            4'd5:    a = 25'sd83416;
            4'd6:    a = 25'sd41718;
            4'd7:    a = 25'sd20860;
            4'd8:    a = 25'sd10430;
            4'd9:    a = 25'sd5215;
            4'd10:   a = 25'sd2608;
            4'd11:   a = 25'sd1304;
            4'd12:   a = 25'sd652;
            4'd13:   a = 25'sd326;
            4'd14:   a = 25'sd163;
            4'd15:   a = 25'sd81;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/vrp_sincos.sv =====
// Shared CORDIC sequencer that turns each written angle into cosine and sine.
module vrp_sincos (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [vrp_pkg::NUM_AXES-1:0]         i_wr,
    input  logic [vrp_pkg::NUM_AXES-1:0][15:0]   i_angles,
    output vrp_pkg::t_trig [vrp_pkg::NUM_AXES-1:0] o_trig,
    output logic                                 o_busy
);
    import vrp_pkg::*;

    t_sc_state                   r_state, n_state;
    logic [NUM_AXES-1:0]         r_pending, n_pending;
    logic [1:0]                  r_axis, n_axis;
    logic [15:0]                 r_angle, n_angle;
    logic signed [CORDIC_W-1:0]  r_x, n_x, r_y, n_y;
    logic signed [ZACC_W-1:0]    r_z, n_z;
    logic [STEP_W-1:0]           r_step, n_step;
    t_trig [NUM_AXES-1:0]        r_trig, n_trig;

    logic [1:0]                  pick;
    logic signed [CORDIC_W-1:0]  dx, dy, rx, ry;
    logic signed [TRIG_W-1:0]    c0, s0;
    t_trig                       quad_out;

    function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [17:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > 18'sd16384) begin
            r = TRIG_ONE;
        end else if (v < -18'sd16384) begin
            r = -TRIG_ONE;
        end else begin
            r = v[TRIG_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SC_IDLE;
            r_pending <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_trig[i].cs <= TRIG_ONE;
                r_trig[i].sn <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_trig    <= n_trig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis  <= n_axis;
        r_angle <= n_angle;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_step  <= n_step;
    end

    always_comb begin
        pick = AXIS_X;
        for (int i = NUM_AXES - 1; i >= 0; i--) begin
            if (r_pending[i]) pick = 2'(i);
        end
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        rx = r_x + 34'sd32768;
        ry = r_y + 34'sd32768;
        if (r_angle[13:0] == 14'd0) begin
            c0 = TRIG_ONE;
            s0 = '0;
        end else begin
            c0 = clamp_trig(rx[CORDIC_W-1:16]);
            s0 = clamp_trig(ry[CORDIC_W-1:16]);
        end
        case (r_angle[15:14])
            2'd0: begin
                quad_out.cs = c0;
                quad_out.sn = s0;
            end
            2'd1: begin
                quad_out.cs = -s0;
                quad_out.sn = c0;
            end
            2'd2: begin
                quad_out.cs = -c0;
                quad_out.sn = -s0;
            end
            default: begin
                quad_out.cs = s0;
                quad_out.sn = -c0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_axis    = r_axis;
        n_angle   = r_angle;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_step    = r_step;
        n_trig    = r_trig;
        case (r_state)
            SC_IDLE: begin
                if (|r_pending) begin
                    n_pending[pick] = 1'b0;
                    n_axis  = pick;
                    n_angle = i_angles[pick];
                    n_x     = CORDIC_GAIN;
                    n_y     = '0;
                    n_z     = {3'b000, i_angles[pick][13:0], 8'h00};
                    n_step  = '0;
                    n_state = SC_RUN;
                end
            end
            SC_RUN: begin
                if (!r_z[ZACC_W-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - step_angle(r_step);
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + step_angle(r_step);
                end
                n_step = r_step + 4'd1;
                if (r_step == STEP_W'(NUM_STEPS - 1)) n_state = SC_FINISH;
            end
            SC_FINISH: begin
                n_trig[r_axis] = quad_out;
                n_state = SC_IDLE;
            end
            default: n_state = SC_IDLE;
        endcase
        // a rewrite during a run queues that axis again
        n_pending = n_pending | i_wr;
    end

    assign o_trig = r_trig;
    assign o_busy = (r_state != SC_IDLE) || (|r_pending);

endmodule

// ===== design/vrp_rot.sv =====
// Two-stage plane rotation: p = a*c - b*s, q = a*s + b*c, rounded from Q1.14.
module vrp_rot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_a,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_b,
    input  vrp_pkg::t_trig                      i_trig,
    output logic                                o_valid,
    output logic signed [vrp_pkg::COORD_W-1:0]  o_p,
    output logic signed [vrp_pkg::COORD_W-1:0]  o_q
);
    import vrp_pkg::*;

    localparam int SUM_W = PROD_W + 1;

    logic                      r_v1, r_v2;
    logic signed [PROD_W-1:0]  r_ac, r_bs, r_as, r_bc;
    logic signed [PROD_W-1:0]  n_ac, n_bs, n_as, n_bc;
    logic signed [SUM_W-1:0]   sum_p, sum_q;
    logic signed [COORD_W-1:0] r_p, r_q;

    always_comb begin
        n_ac  = i_a * i_trig.cs;
        n_bs  = i_b * i_trig.sn;
        n_as  = i_a * i_trig.sn;
        n_bc  = i_b * i_trig.cs;
        sum_p = SUM_W'(r_ac) - SUM_W'(r_bs) + SUM_W'(8192);
        sum_q = SUM_W'(r_as) + SUM_W'(r_bc) + SUM_W'(8192);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ac <= n_ac;
        r_bs <= n_bs;
        r_as <= n_as;
        r_bc <= n_bc;
        r_p  <= sum_p[COORD_W+13:14];
        r_q  <= sum_q[COORD_W+13:14];
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_q     = r_q;

endmodule

// ===== design/vrp_proj.sv =====
// Perspective divide of one coordinate: round(4800*num/den), one quotient bit per stage.
module vrp_proj (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_num,
    input  logic [vrp_pkg::DEN_W-1:0]           i_den,
    output logic                                o_valid,
    output logic signed [15:0]                  o_screen
);
    import vrp_pkg::*;

    logic                 r_va;
    logic [MAG_W-1:0]     r_m;
    logic [DEN_W-1:0]     r_den;
    logic                 r_nega;
    logic [COORD_W-1:0]   mag;
    logic [NUM_W-1:0]     np;
    logic [DIV_W-1:0]     dvs;

    logic [DIV_W-1:0]     r_rem [QUOT_W+1];
    logic [QUOT_W-1:0]    r_q   [QUOT_W+1];
    logic [QUOT_W-1:0]    r_nlo [QUOT_W+1];
    logic [DIV_W-1:0]     r_dvs [QUOT_W+1];
    logic                 r_neg [QUOT_W+1];
    logic                 r_ovf [QUOT_W+1];
    logic                 r_v   [QUOT_W+1];

    logic                 r_vo;
    logic signed [15:0]   r_out, n_out;
    logic [QUOT_W-1:0]    qf;

    always_comb begin
        mag = i_num[COORD_W-1] ? COORD_W'(-i_num) : COORD_W'(i_num);
        np  = {r_m, 1'b0} + NUM_W'(r_den);
        dvs = {r_den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_v[0] <= 1'b0;
        end else begin
            r_va   <= i_valid;
            r_v[0] <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= MAG_W'(mag) * PROJ_SCALE;
        r_den    <= i_den;
        r_nega   <= i_num[COORD_W-1];
        // quotient past 17 bits saturates anyway
        r_ovf[0] <= ({4'h0, np} >= {dvs, 17'h00000});
        r_rem[0] <= DIV_W'(np[NUM_W-1:QUOT_W]);
        r_nlo[0] <= np[QUOT_W-1:0];
        r_q[0]   <= '0;
        r_dvs[0] <= dvs;
        r_neg[0] <= r_nega;
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        logic [DIV_W:0] t;
        logic           ge;
        assign t  = {r_rem[k], r_nlo[k][QUOT_W-1-k]};
        assign ge = (t >= {1'b0, r_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? DIV_W'(t - {1'b0, r_dvs[k]}) : t[DIV_W-1:0];
            r_q[k+1]   <= {r_q[k][QUOT_W-2:0], ge};
            r_nlo[k+1] <= r_nlo[k];
            r_dvs[k+1] <= r_dvs[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    always_comb begin
        qf = r_q[QUOT_W];
        if (!r_neg[QUOT_W]) begin
            if (r_ovf[QUOT_W] || qf > 17'd32767) begin
                n_out = 16'sh7fff;
            end else begin
                n_out = qf[15:0];
            end
        end else begin
            if (r_ovf[QUOT_W] || qf > 17'd32768) begin
                n_out = -16'sh8000;
            end else begin
                n_out = -qf[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_vo;
    assign o_screen = r_out;

endmodule

// ===== design/vertex_rotate_project.sv =====
// An accepted vertex passes the rotation stages, then the divide, and strobes on o_valid.
// Throughput: one vertex per cycle unless busy; the divider retires one quotient bit per stage.
// An angle write holds busy high while the shared CORDIC runs for that axis.
// The receiver cannot stall; results show for one cycle only.
// Reset: synchronous active low; angles clear to zero, cosine 1 and sine 0, pipeline empties.
// Top level: APB angle registers, three rotation stages and two perspective dividers.
module vertex_rotate_project (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  vrp_pkg::t_vertex  i_vertex,
    output logic              o_valid,
    output vrp_pkg::t_result  o_result
);
    import vrp_pkg::*;

    logic [NUM_AXES-1:0][15:0]  r_angle;
    logic [NUM_AXES-1:0]        wr;
    logic [1:0]                 idx;
    logic                       apb_wr;
    t_trig [NUM_AXES-1:0]       trig;
    t_trig                      trig_y;
    logic                       accept;

    logic                       vx, vy, vz;
    logic signed [COORD_W-1:0]  y1, z1, x2, z2, x3, y3;
    logic signed [COORD_W-1:0]  r_xd [2];
    logic signed [COORD_W-1:0]  r_yd [2];
    logic signed [COORD_W-1:0]  r_zd [2];

    logic signed [DIV_W-1:0]    eye_den;
    logic                       behind;
    logic signed [15:0]         depth;
    logic [16:0]                r_side [PROJ_LAT];
    logic                       px_v, py_v;
    logic signed [15:0]         sx, sy;

    assign apb_wr = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            wr[i] = apb_wr && (idx == 2'(i));
        end
        case (idx)
            AXIS_X:  prdata = {16'h0000, r_angle[AXIS_X]};
            AXIS_Y:  prdata = {16'h0000, r_angle[AXIS_Y]};
            AXIS_Z:  prdata = {16'h0000, r_angle[AXIS_Z]};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (wr[i]) r_angle[i] <= pwdata[15:0];
            end
        end
    end

    vrp_sincos u_sincos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_angles (r_angle),
        .o_trig   (trig),
        .o_busy   (busy)
    );

    assign accept = start && !busy;

    // rotation about Y uses the opposite sign of sine
    always_comb begin
        trig_y.cs = trig[AXIS_Y].cs;
        trig_y.sn = -trig[AXIS_Y].sn;
    end

    vrp_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_a     (COORD_W'(i_vertex.in_y)),
        .i_b     (COORD_W'(i_vertex.in_z)),
        .i_trig  (trig[AXIS_X]),
        .o_valid (vx),
        .o_p     (y1),
        .o_q     (z1)
    );

    vrp_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vx),
        .i_a     (r_xd[1]),
        .i_b     (z1),
        .i_trig  (trig_y),
        .o_valid (vy),
        .o_p     (x2),
        .o_q     (z2)
    );

    vrp_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vy),
        .i_a     (x2),
        .i_b     (r_yd[1]),
        .i_trig  (trig[AXIS_Z]),
        .o_valid (vz),
        .o_p     (x3),
        .o_q     (y3)
    );

    // carry the untouched coordinate alongside each rotation
    always_ff @(posedge i_clk) begin
        r_xd[0] <= COORD_W'(i_vertex.in_x);
        r_xd[1] <= r_xd[0];
        r_yd[0] <= y1;
        r_yd[1] <= r_yd[0];
        r_zd[0] <= z2;
        r_zd[1] <= r_zd[0];
    end

    always_comb begin
        eye_den = DIV_W'(r_zd[1]) + EYE_DIST;
        behind  = eye_den[DIV_W-1] || (eye_den == '0);
        if (r_zd[1] > 18'sd32767) begin
            depth = 16'sh7fff;
        end else if (r_zd[1] < -18'sd32768) begin
            depth = -16'sh8000;
        end else begin
            depth = r_zd[1][15:0];
        end
    end

    vrp_proj u_proj_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (vz),
        .i_num    (x3),
        .i_den    (eye_den[DEN_W-1:0]),
        .o_valid  (px_v),
        .o_screen (sx)
    );

    vrp_proj u_proj_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (vz),
        .i_num    (y3),
        .i_den    (eye_den[DEN_W-1:0]),
        .o_valid  (py_v),
        .o_screen (sy)
    );

    always_ff @(posedge i_clk) begin
        r_side[0] <= {behind, depth};
        for (int i = 1; i < PROJ_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    assign o_valid             = px_v && py_v;
    assign o_result.behind_eye = r_side[PROJ_LAT-1][16];
    assign o_result.depth_z    = r_side[PROJ_LAT-1][15:0];
    assign o_result.screen_x   = r_side[PROJ_LAT-1][16] ? 16'sh0000 : sx;
    assign o_result.screen_y   = r_side[PROJ_LAT-1][16] ? 16'sh0000 : sy;

endmodule

// ===== design/vrp_checker.sv =====
// Port-level checks on the vertex rotate and project block, bound to the top level.
module vrp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              start,
    input  logic              busy,
    input  vrp_pkg::t_vertex  i_vertex,
    input  logic              o_valid,
    input  vrp_pkg::t_result  o_result
);
    import vrp_pkg::*;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_valid)
        else $error("accepted item produced no result on time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without a matching accepted item");

    a_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.behind_eye) |->
            (o_result.screen_x == 16'sh0000 && o_result.screen_y == 16'sh0000))
        else $error("behind-eye result with nonzero screen coordinates");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(psel && penable && pwrite && pready))
        else $error("busy rose without an angle write");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);

// ===== sim/tb_vertex_rotate_project.sv =====
// Self-checking testbench for the vertex rotate and project pipeline.
module tb_vertex_rotate_project;
    import vrp_pkg::*;

    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT  = 600000;
    localparam logic [3:0] ADDR_ANGLE_X = 4'd0;
    localparam logic [3:0] ADDR_ANGLE_Y = 4'd4;
    localparam logic [3:0] ADDR_ANGLE_Z = 4'd8;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    t_vertex     i_vertex;
    logic        o_valid;
    t_result     o_result;

    // Angles as seen by the predictor
    logic [15:0] ang_x, ang_y, ang_z;
    t_result     pending_results[$];
    int          err_count;
    int          cycle_count;
    int          idle_pct;

    const longint ATAN_TURN[16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    vertex_rotate_project i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .i_vertex (i_vertex),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint clamp_val(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic trig_of_angle(input logic [15:0] ang, output longint cs, output longint sn);
        longint cx, sy, za, dx, dy, c0, s0;
        if (ang[13:0] == 14'd0) begin
            c0 = 16384;
            s0 = 0;
        end else begin
            cx = 652032874;
            sy = 0;
            za = longint'(ang[13:0]) << 8;
            for (int i = 0; i < 16; i++) begin
                dx = sy >>> i;
                dy = cx >>> i;
                if (za >= 0) begin
                    cx -= dx; sy += dy; za -= ATAN_TURN[i];
                end else begin
                    cx += dx; sy -= dy; za += ATAN_TURN[i];
                end
            end
            c0 = clamp_val((cx + 32768) >>> 16, -16384, 16384);
            s0 = clamp_val((sy + 32768) >>> 16, -16384, 16384);
        end
        case (ang[15:14])
            2'd0: begin cs = c0;  sn = s0;  end
            2'd1: begin cs = -s0; sn = c0;  end
            2'd2: begin cs = -c0; sn = -s0; end
            default: begin cs = s0; sn = -c0; end
        endcase
    endtask

    function automatic longint rot_round(longint a, longint p, longint b, longint q);
        return (a * p + b * q + 8192) >>> 14;
    endfunction

    function automatic longint persp_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    task automatic project_vertex(input t_vertex v, output t_result r);
        longint px, py, pz, t, c, s, den;
        px = v.in_x;
        py = v.in_y;
        pz = v.in_z;
        trig_of_angle(ang_x, c, s);
        t  = rot_round(py, c, pz, -s);
        pz = rot_round(py, s, pz, c);
        py = t;
        trig_of_angle(ang_y, c, s);
        t  = rot_round(px, c, pz, s);
        pz = rot_round(px, -s, pz, c);
        px = t;
        trig_of_angle(ang_z, c, s);
        t  = rot_round(px, c, py, -s);
        py = rot_round(px, s, py, c);
        px = t;
        den = 768 + pz;
        r.behind_eye = (den <= 0);
        if (den <= 0) begin
            r.screen_x = '0;
            r.screen_y = '0;
        end else begin
            r.screen_x = 16'(clamp_val(persp_div(px * 4800, den), -32768, 32767));
            r.screen_y = 16'(clamp_val(persp_div(py * 4800, den), -32768, 32767));
        end
        r.depth_z = 16'(clamp_val(pz, -32768, 32767));
    endtask

    // Send one item; hold start high while busy, then maybe idle
    task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vz);
        t_vertex v;
        t_result r;
        int gap;
        v.in_x = vx;
        v.in_y = vy;
        v.in_z = vz;
        i_vertex <= v;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy);
        project_vertex(v, r);
        pending_results.push_back(r);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_angle(input logic [3:0] addr, input logic [15:0] val);
        while (busy) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_ANGLE_X: ang_x = val;
            ADDR_ANGLE_Y: ang_y = val;
            default:      ang_z = val;
        endcase
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_angles(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az);
        wait_drained();
        write_angle(ADDR_ANGLE_X, ax);
        write_angle(ADDR_ANGLE_Y, ay);
        write_angle(ADDR_ANGLE_Z, az);
    endtask

    task automatic test_field_extremes;
        idle_pct = 0;
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h7fff, 16'h8000, 16'h0000);
        send_vertex(16'h0100, 16'hff00, 16'h0100);
        // Near the eye plane the projection saturates
        send_vertex(16'h7fff, 16'h8000, -16'sd767);
    endtask

    task automatic test_behind_eye;
        send_vertex(16'h0100, 16'h0100, -16'sd768);
        send_vertex(16'h0064, 16'hff9c, -16'sd769);
        send_vertex(16'h1234, 16'h4321, 16'h8000);
    endtask

    task automatic test_quadrant_angles;
        set_angles(16'h4000, 16'h8000, 16'hc000);
        send_vertex(16'h0100, 16'h0200, 16'h0300);
        send_vertex(16'h8000, 16'h7fff, 16'hfd00);
        set_angles(16'hffff, 16'hffff, 16'hffff);
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
        send_vertex(16'h0100, 16'hff00, 16'h0080);
        set_angles(16'h0001, 16'h3fff, 16'h2000);
        send_vertex(16'h0100, 16'h0200, 16'hfe00);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
    endtask

    task automatic test_random_vertices(input int count, input int pct);
        logic [15:0] rx, ry, rz;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1) == 0) begin
                rx = 16'($urandom);
                ry = 16'($urandom);
                rz = 16'($urandom);
            end else begin
                rx = 16'($signed($urandom_range(2047)) - 1024);
                ry = 16'($signed($urandom_range(2047)) - 1024);
                rz = 16'($signed($urandom_range(2047)) - 1024);
            end
            send_vertex(rx, ry, rz);
        end
    endtask

    task automatic test_random_angles;
        int pcts[4] = '{0, 62, 0, 32};
        for (int ph = 0; ph < 8; ph++) begin
            set_angles(16'($urandom), 16'($urandom), 16'($urandom));
            test_random_vertices(128, pcts[ph % 4]);
        end
        set_angles(16'h0000, 16'h0000, 16'h0000);
        test_random_vertices(20, 62);
    endtask

    // Compare each result against the oldest expected one
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_result);
                err_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result.screen_x !== e.screen_x) begin
                    $error("screen_x expected %0d actual %0d", e.screen_x, o_result.screen_x);
                    err_count++;
                end
                if (o_result.screen_y !== e.screen_y) begin
                    $error("screen_y expected %0d actual %0d", e.screen_y, o_result.screen_y);
                    err_count++;
                end
                if (o_result.depth_z !== e.depth_z) begin
                    $error("depth_z expected %0d actual %0d", e.depth_z, o_result.depth_z);
                    err_count++;
                end
                if (o_result.behind_eye !== e.behind_eye) begin
                    $error("behind_eye expected %0d actual %0d",
                           e.behind_eye, o_result.behind_eye);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        err_count   = 0;
        cycle_count = 0;
        idle_pct    = 0;
        ang_x = '0;
        ang_y = '0;
        ang_z = '0;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        i_vertex = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        test_field_extremes();
        test_behind_eye();
        test_quadrant_angles();
        test_random_angles();

        wait_drained();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
